FILE: sv/sb64d_pkg.sv
// package for the strict base64 decoder: result item type, push bundle,
// character and status codes, result buffer sizes and the alphabet lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sb64d_pkg;

	// input action codes
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// end status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	// special characters
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_ZERO    = 8'h30;

	localparam logic [5:0] SX_LOWER_BASE = 6'd26;
	localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SX_PLUS       = 6'd62;
	localparam logic [5:0] SX_SLASH      = 6'd63;

	// most results that one input item causes
	localparam int MAX_RES = 3;

	// result buffer
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam logic [CNT_W-1:0] READY_MAX_BUSY = CNT_W'(FIFO_DEPTH - 2 * MAX_RES);
	localparam logic [CNT_W-1:0] READY_MAX_IDLE = CNT_W'(FIFO_DEPTH - MAX_RES);

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic [15:0] decoded_length;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]          num;
		result_t [MAX_RES-1:0] item;
	} push_t;

	// returns {valid, sextet}
	function automatic logic [6:0] sextet_of(logic [7:0] ch);
		logic [7:0] v;
		logic       ok;
		v  = '0;
		ok = 1'b1;
		if (ch inside {[8'h41:8'h5A]}) begin
			v = ch - CH_UPPER_A;
		end else if (ch inside {[8'h61:8'h7A]}) begin
			v = ch - CH_LOWER_A + {2'b00, SX_LOWER_BASE};
		end else if (ch inside {[8'h30:8'h39]}) begin
			v = ch - CH_ZERO + {2'b00, SX_DIGIT_BASE};
		end else if (ch == CH_PLUS) begin
			v = {2'b00, SX_PLUS};
		end else if (ch == CH_SLASH) begin
			v = {2'b00, SX_SLASH};
		end else begin
			ok = 1'b0;
		end
		return {ok, v[5:0]};
	endfunction

endpackage

`default_nettype wire

FILE: sv/strict_base64_decoder_top.sv
// strict base64 decoder top level: input register, decode stage, result buffer
// depends on sb64d_pkg, sb64d_core, sb64d_fifo
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata char_code, tuser action
// m_*       out  m_tvalid/m_tready   tdata data_byte/status/length, tuser kind, tlast last
// cfg_*     in   cfg_wr_en           cfg_wr_data byte_capacity
//
// one input item per cycle while s_tready is high; it is registered, decoded the
// next cycle and its zero to three results enter a sixteen-entry result buffer
// results leave one per cycle while m_tready is high; a group of four characters
// yields at most three of them
// s_tready drops only when the result buffer is close to full
// reset clears string state, buffer pointers and sets capacity to 65535
`timescale 1ns / 1ps
`default_nettype none

module strict_base64_decoder_top #(
	parameter int LENGTH_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire         s_tuser,   // [0] action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [7:0] data_byte, [9:8] status, [25:10] decoded_length
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data
);

	logic       valid_s1;
	logic       action_s1;
	logic [7:0] char_s1;

	sb64d_pkg::push_t            push;
	sb64d_pkg::result_t          head;
	logic [sb64d_pkg::CNT_W-1:0] count;
	logic                        pop;

	// leave room for the item in the stage and the one being accepted
	assign s_tready = valid_s1 ? (count <= sb64d_pkg::READY_MAX_BUSY)
	                           : (count <= sb64d_pkg::READY_MAX_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			char_s1   <= s_tdata;
		end
	end

	sb64d_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.valid_s1   (valid_s1),
		.action_s1  (action_s1),
		.char_s1    (char_s1),
		.push       (push)
	);

	sb64d_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.count (count)
	);

	assign m_tvalid = (count != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = {6'd0, head.decoded_length, head.status, head.data_byte};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

endmodule

`default_nettype wire

FILE: sv/sb64d_fifo.sv
// result buffer: takes up to three result items per cycle, gives one per cycle on pop
// depends on sb64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module sb64d_fifo (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire sb64d_pkg::push_t        push,
	input  wire                          pop,
	output sb64d_pkg::result_t           head,
	output logic [sb64d_pkg::CNT_W-1:0]  count
);

	sb64d_pkg::result_t mem_q [sb64d_pkg::FIFO_DEPTH];

	logic [sb64d_pkg::PTR_W-1:0] wr_ptr_q;
	logic [sb64d_pkg::PTR_W-1:0] rd_ptr_q;
	logic [sb64d_pkg::CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < sb64d_pkg::MAX_RES; k++) begin
			if (2'(k) < push.num) begin
				mem_q[sb64d_pkg::PTR_W'(wr_ptr_q + sb64d_pkg::PTR_W'(k))] <= push.item[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= sb64d_pkg::PTR_W'(wr_ptr_q + sb64d_pkg::PTR_W'(push.num));
			if (pop) begin
				rd_ptr_q <= sb64d_pkg::PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= sb64d_pkg::CNT_W'(count_q + sb64d_pkg::CNT_W'(push.num)
				- sb64d_pkg::CNT_W'(pop));
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + sb64d_pkg::CNT_W'(push.num)) <= sb64d_pkg::CNT_W'(sb64d_pkg::FIFO_DEPTH))
		else $error("result buffer overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("result buffer read while empty");
`endif

endmodule

`default_nettype wire

FILE: sv/sb64d_core.sv
// decode stage: string state, capacity register and the per-item decode that
// turns one registered input item into zero to three result items
// depends on sb64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module sb64d_core #(
	parameter int LENGTH_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire  [15:0]       cfg_wr_data,
	input  wire               valid_s1,
	input  wire               action_s1,
	input  wire  [7:0]        char_s1,
	output sb64d_pkg::push_t  push
);

	localparam int CW = (LENGTH_BITS + 1 > 17) ? LENGTH_BITS + 1 : 17;
	localparam logic [LENGTH_BITS:0] CNT_SAT = {1'b1, {LENGTH_BITS{1'b0}}};

	logic [15:0]          capacity_q;
	logic [17:0]          hold_q;
	logic [1:0]           pos_q;
	logic                 third_pad_q;
	logic                 pad_seen_q;
	logic                 malformed_q;
	logic [LENGTH_BITS:0] bytes_q;

	logic [17:0]          hold_d;
	logic [1:0]           pos_d;
	logic                 third_pad_d;
	logic                 pad_seen_d;
	logic                 malformed_d;
	logic [LENGTH_BITS:0] bytes_d;

	logic [6:0]             sx;
	logic                   is_pad;
	logic [23:0]            word;
	logic [1:0]             n_bytes;
	logic [LENGTH_BITS+1:0] sum;
	logic [LENGTH_BITS-1:0] len_sat;
	logic [CW-1:0]          len_w;
	logic                   bad_end;

	always_comb begin
		hold_d      = hold_q;
		pos_d       = pos_q;
		third_pad_d = third_pad_q;
		pad_seen_d  = pad_seen_q;
		malformed_d = malformed_q;
		bytes_d     = bytes_q;
		push        = '0;

		sx      = sb64d_pkg::sextet_of(char_s1);
		is_pad  = (char_s1 == sb64d_pkg::CH_PAD);
		word    = {hold_q, (is_pad ? 6'd0 : sx[5:0])};
		n_bytes = third_pad_q ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
		sum     = {1'b0, bytes_q} + (LENGTH_BITS+2)'(n_bytes);
		len_sat = bytes_q[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : bytes_q[LENGTH_BITS-1:0];
		len_w   = CW'(len_sat);
		bad_end = malformed_q || (pos_q != 2'd0);

		if (valid_s1) begin
			if (action_s1 == sb64d_pkg::ACT_END) begin
				push.num                = 2'd1;
				push.item[0].kind       = sb64d_pkg::KIND_STATUS;
				push.item[0].last       = 1'b1;
				if (bad_end) begin
					push.item[0].status = sb64d_pkg::ST_MALFORMED;
				end else begin
					push.item[0].decoded_length = len_w[15:0];
					push.item[0].status = (CW'(bytes_q) > CW'(capacity_q))
						? sb64d_pkg::ST_TOO_LONG : sb64d_pkg::ST_OK;
				end
				hold_d      = '0;
				pos_d       = '0;
				third_pad_d = 1'b0;
				pad_seen_d  = 1'b0;
				malformed_d = 1'b0;
				bytes_d     = '0;
			end else if (char_s1 == sb64d_pkg::CH_CR || char_s1 == sb64d_pkg::CH_LF
					|| malformed_q) begin
				// skipped
			end else if (pad_seen_q && pos_q == 2'd0) begin
				// character after a closed padded group
				malformed_d = 1'b1;
			end else if (is_pad && pos_q < 2'd2) begin
				malformed_d = 1'b1;
			end else if (!is_pad && (!sx[6] || third_pad_q)) begin
				malformed_d = 1'b1;
			end else if (pos_q != 2'd3) begin
				// open group grows by one sextet, a third-place pad shifts in zero
				hold_d = {hold_q[11:0], (is_pad ? 6'd0 : sx[5:0])};
				pos_d  = pos_q + 2'd1;
				if (is_pad) begin
					pad_seen_d  = 1'b1;
					third_pad_d = 1'b1;
				end
			end else begin
				// fourth place closes the group
				if (is_pad) begin
					pad_seen_d = 1'b1;
				end
				push.num = n_bytes;
				for (int k = 0; k < sb64d_pkg::MAX_RES; k++) begin
					push.item[k].kind      = sb64d_pkg::KIND_DATA;
					push.item[k].data_byte = word[23-8*k -: 8];
					push.item[k].last      = (2'(k) == n_bytes - 2'd1);
				end
				bytes_d     = (sum > {1'b0, CNT_SAT}) ? CNT_SAT : sum[LENGTH_BITS:0];
				hold_d      = '0;
				pos_d       = '0;
				third_pad_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= 16'hFFFF;
			hold_q      <= '0;
			pos_q       <= '0;
			third_pad_q <= 1'b0;
			pad_seen_q  <= 1'b0;
			malformed_q <= 1'b0;
			bytes_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			hold_q      <= hold_d;
			pos_q       <= pos_d;
			third_pad_q <= third_pad_d;
			pad_seen_q  <= pad_seen_d;
			malformed_q <= malformed_d;
			bytes_q     <= bytes_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && action_s1 == sb64d_pkg::ACT_END) |=>
		(pos_q == 2'd0 && !malformed_q && !pad_seen_q && bytes_q == '0))
		else $error("string state not cleared after end item");

	a_quiet_when_malformed: assert property (@(posedge clk) disable iff (!arst_n)
		(malformed_q && !(valid_s1 && action_s1 == sb64d_pkg::ACT_END)) |-> push.num == 2'd0)
		else $error("data emitted for a malformed string");
`endif

endmodule

`default_nettype wire

FILE: bench/sb64d_decode_monitor.sv
// result checker for the strict base64 decoder: tracks accepted input items,
// predicts the decoded bytes and end status, and compares every output item
// depends on sb64d_pkg
`timescale 1ns / 1ps

module sb64d_decode_monitor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire         s_tuser,   // [0] action
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,   // [7:0] data_byte, [9:8] status, [25:10] decoded_length
	input  wire         m_tuser,   // [0] kind
	input  wire         m_tlast,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	output int          error_count,
	output int          pending_count,
	output int          bytes_checked,
	output int          ok_count,
	output int          malformed_count,
	output int          over_count
);

	localparam logic [16:0] COUNT_SAT = 17'h10000;
	localparam logic [16:0] LEN_MAX   = 17'h0FFFF;

	// shadow of the decoder
	logic [15:0] capacity;
	logic [17:0] sextets;
	logic [1:0]  slot;
	logic        third_pad;
	logic        any_pad;
	logic        broken;
	logic [16:0] decoded_count;

	sb64d_pkg::result_t awaited_results[$];

	function automatic int sextet_value(logic [7:0] ch);
		if (ch >= sb64d_pkg::CH_UPPER_A && ch <= sb64d_pkg::CH_UPPER_A + 8'd25)
			return int'(ch - sb64d_pkg::CH_UPPER_A);
		if (ch >= sb64d_pkg::CH_LOWER_A && ch <= sb64d_pkg::CH_LOWER_A + 8'd25)
			return int'(ch - sb64d_pkg::CH_LOWER_A) + int'(sb64d_pkg::SX_LOWER_BASE);
		if (ch >= sb64d_pkg::CH_ZERO && ch <= sb64d_pkg::CH_ZERO + 8'd9)
			return int'(ch - sb64d_pkg::CH_ZERO) + int'(sb64d_pkg::SX_DIGIT_BASE);
		if (ch == sb64d_pkg::CH_PLUS)
			return int'(sb64d_pkg::SX_PLUS);
		if (ch == sb64d_pkg::CH_SLASH)
			return int'(sb64d_pkg::SX_SLASH);
		return -1;
	endfunction

	task automatic clear_string();
		sextets       = '0;
		slot          = '0;
		third_pad     = 1'b0;
		any_pad       = 1'b0;
		broken        = 1'b0;
		decoded_count = '0;
	endtask

	task automatic expect_result(logic kind, logic [7:0] data, logic [1:0] st,
			logic [15:0] len, logic last_flag);
		sb64d_pkg::result_t r;
		r.kind           = kind;
		r.data_byte      = data;
		r.status         = st;
		r.decoded_length = len;
		r.last           = last_flag;
		awaited_results.push_back(r);
	endtask

	task automatic decode_item(logic act, logic [7:0] ch);
		int          v;
		int          n;
		logic [23:0] word;
		logic [1:0]  st;
		if (act == sb64d_pkg::ACT_END) begin
			if (slot != 2'd0)
				broken = 1'b1;
			if (broken) begin
				expect_result(sb64d_pkg::KIND_STATUS, 8'h00, sb64d_pkg::ST_MALFORMED,
					16'd0, 1'b1);
			end else begin
				st = (decoded_count > {1'b0, capacity}) ? sb64d_pkg::ST_TOO_LONG
					: sb64d_pkg::ST_OK;
				expect_result(sb64d_pkg::KIND_STATUS, 8'h00, st,
					(decoded_count > LEN_MAX) ? 16'hFFFF : decoded_count[15:0], 1'b1);
			end
			clear_string();
			return;
		end
		if (ch == sb64d_pkg::CH_CR || ch == sb64d_pkg::CH_LF || broken)
			return;
		// nothing may follow a finished group that carried padding
		if (any_pad && slot == 2'd0) begin
			broken = 1'b1;
			return;
		end
		v = sextet_value(ch);
		if (ch == sb64d_pkg::CH_PAD) begin
			if (slot < 2'd2) begin
				broken = 1'b1;
				return;
			end
			any_pad = 1'b1;
			if (slot == 2'd2) begin
				third_pad = 1'b1;
				sextets   = {sextets[11:0], 6'd0};
				slot      = 2'd3;
				return;
			end
			v = 0;
		end else begin
			if (v < 0 || third_pad) begin
				broken = 1'b1;
				return;
			end
			if (slot != 2'd3) begin
				sextets = {sextets[11:0], 6'(v)};
				slot    = slot + 2'd1;
				return;
			end
		end
		// fourth place closes the group
		word = {sextets, 6'(v)};
		n = third_pad ? 1 : ((ch == sb64d_pkg::CH_PAD) ? 2 : 3);
		for (int k = 0; k < n; k++)
			expect_result(sb64d_pkg::KIND_DATA, word[23 - 8 * k -: 8], sb64d_pkg::ST_OK,
				16'd0, k == n - 1);
		decoded_count = (decoded_count + 17'(n) > COUNT_SAT) ? COUNT_SAT
			: decoded_count + 17'(n);
		sextets   = '0;
		slot      = '0;
		third_pad = 1'b0;
	endtask

	task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
	endtask

	task automatic check_result();
		sb64d_pkg::result_t want;
		if (awaited_results.size() == 0) begin
			error_count++;
			$display("%0t: unexpected item, expected none, got tdata %h tuser %b tlast %b",
				$time, m_tdata, m_tuser, m_tlast);
			return;
		end
		want = awaited_results.pop_front();
		if (m_tuser !== want.kind)
			report_field("kind", 32'(want.kind), 32'(m_tuser));
		if (m_tdata[7:0] !== want.data_byte)
			report_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
		if (m_tdata[9:8] !== want.status)
			report_field("status", 32'(want.status), 32'(m_tdata[9:8]));
		if (m_tdata[25:10] !== want.decoded_length)
			report_field("decoded_length", 32'(want.decoded_length), 32'(m_tdata[25:10]));
		if (m_tlast !== want.last)
			report_field("last", 32'(want.last), 32'(m_tlast));
		if (m_tdata[31:26] !== 6'd0)
			report_field("tdata fill", 32'd0, 32'(m_tdata[31:26]));
		if (want.kind == sb64d_pkg::KIND_DATA)
			bytes_checked++;
		else if (want.status == sb64d_pkg::ST_OK)
			ok_count++;
		else if (want.status == sb64d_pkg::ST_MALFORMED)
			malformed_count++;
		else
			over_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = 16'hFFFF;
			clear_string();
			awaited_results.delete();
			error_count     = 0;
			bytes_checked   = 0;
			ok_count        = 0;
			malformed_count = 0;
			over_count      = 0;
		end else begin
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			if (s_tvalid && s_tready)
				decode_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
		pending_count = awaited_results.size();
	end

endmodule

FILE: bench/tb_strict_base64_decoder_top.sv
// testbench top for the strict base64 decoder: clock, reset, string stimulus,
// output back-pressure, capacity writes and the final verdict
// depends on sb64d_pkg, strict_base64_decoder_top, sb64d_decode_monitor
`timescale 1ns / 1ps

module tb_strict_base64_decoder_top;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 20;
	localparam int HOLD_CYCLES   = 100;
	localparam int FLOOD_GROUPS  = 8;

	typedef enum int {
		FAULT_STRAY_BYTE,
		FAULT_DROP_CHAR,
		FAULT_STRAY_PAD,
		FAULT_EXTRA_CHAR,
		FAULT_REPLACE_CHAR
	} string_fault_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	int error_count;
	int pending_count;
	int bytes_checked;
	int ok_count;
	int malformed_count;
	int over_count;

	int cycle_count  = 0;
	int items_sent   = 0;
	int strings_sent = 0;

	bit sender_burst = 1'b0;
	bit hold_request = 1'b0;
	bit hold_active  = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	strict_base64_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	sb64d_decode_monitor u_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.error_count     (error_count),
		.pending_count   (pending_count),
		.bytes_checked   (bytes_checked),
		.ok_count        (ok_count),
		.malformed_count (malformed_count),
		.over_count      (over_count)
	);

	// mostly short idles, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] alphabet_char(int idx);
		if (idx < int'(sb64d_pkg::SX_LOWER_BASE))
			return sb64d_pkg::CH_UPPER_A + 8'(idx);
		if (idx < int'(sb64d_pkg::SX_DIGIT_BASE))
			return sb64d_pkg::CH_LOWER_A + 8'(idx - int'(sb64d_pkg::SX_LOWER_BASE));
		if (idx < int'(sb64d_pkg::SX_PLUS))
			return sb64d_pkg::CH_ZERO + 8'(idx - int'(sb64d_pkg::SX_DIGIT_BASE));
		return (idx == int'(sb64d_pkg::SX_PLUS)) ? sb64d_pkg::CH_PLUS : sb64d_pkg::CH_SLASH;
	endfunction

	function automatic logic [7:0] random_char();
		return alphabet_char($urandom_range(0, 63));
	endfunction

	task automatic send_item(logic act, logic [7:0] ch);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = ch;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (act == sb64d_pkg::ACT_END)
			strings_sent++;
		gap = sender_burst ? 0 : idle_length();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tuser  = 1'($urandom_range(0, 1));
			s_tdata  = 8'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_end();
		send_item(sb64d_pkg::ACT_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(sb64d_pkg::ACT_CHAR, s[i]);
		send_end();
	endtask

	task automatic write_capacity(logic [15:0] value);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 16'd0;
	endtask

	// wait for every predicted item, then for the pipeline to empty
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly well-formed strings with random content, some of them broken
	task automatic send_random_string();
		logic [7:0]    text[$];
		int            groups;
		int            pad;
		int            pos;
		string_fault_t fault;
		groups = $urandom_range(0, 4);
		for (int i = 0; i < 4 * groups; i++)
			text.push_back(random_char());
		if (groups > 0) begin
			pad = $urandom_range(0, 2);
			if (pad >= 1)
				text[text.size() - 1] = sb64d_pkg::CH_PAD;
			if (pad == 2)
				text[text.size() - 2] = sb64d_pkg::CH_PAD;
		end
		if ($urandom_range(0, 99) >= 70) begin
			fault = string_fault_t'($urandom_range(0, 4));
			pos   = $urandom_range(0, text.size());
			case (fault)
				FAULT_STRAY_BYTE: begin
					text.insert(pos, 8'($urandom_range(0, 255)));
				end
				FAULT_DROP_CHAR: begin
					if (text.size() > 0)
						text.delete($urandom_range(0, text.size() - 1));
				end
				FAULT_STRAY_PAD: begin
					text.insert(pos, sb64d_pkg::CH_PAD);
				end
				FAULT_EXTRA_CHAR: begin
					text.push_back(random_char());
				end
				default: begin
					if (text.size() > 0)
						text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
				end
			endcase
		end
		foreach (text[i]) begin
			if ($urandom_range(0, 9) == 0)
				send_item(sb64d_pkg::ACT_CHAR,
					$urandom_range(0, 1) ? sb64d_pkg::CH_CR : sb64d_pkg::CH_LF);
			send_item(sb64d_pkg::ACT_CHAR, text[i]);
		end
		send_end();
	endtask

	task automatic random_phase();
		int start;
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS)
			send_random_string();
	endtask

	// receiver stalls; long holds on request
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				@(negedge clk);
				m_tready    = 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				hold_active  = 1'b0;
			end else begin
				@(negedge clk);
				m_tready = 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
				gap = idle_length();
				if (gap > 0) begin
					m_tready = 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = sb64d_pkg::ACT_CHAR;
		s_tdata     = 8'h00;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 16'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed strings at reset capacity
		send_item(sb64d_pkg::ACT_END, 8'h00);
		send_item(sb64d_pkg::ACT_CHAR, sb64d_pkg::CH_CR);
		send_item(sb64d_pkg::ACT_CHAR, sb64d_pkg::CH_LF);
		send_item(sb64d_pkg::ACT_END, 8'hFF);
		send_text("+/Az");
		send_text("z0==A");
		send_text("A=");
		send_text("AB=C");
		send_item(sb64d_pkg::ACT_CHAR, 8'hFF);
		send_end();
		drain();

		write_capacity(16'h0000);
		random_phase();
		drain();

		// fill the result buffer while the output is held off
		write_capacity(16'd5);
		hold_request = 1'b1;
		wait (hold_active);
		sender_burst = 1'b1;
		for (int g = 0; g < FLOOD_GROUPS; g++)
			repeat (4) send_item(sb64d_pkg::ACT_CHAR, random_char());
		sender_burst = 1'b0;
		send_end();
		random_phase();
		drain();

		write_capacity(16'($urandom_range(1, 12)));
		random_phase();
		drain();

		write_capacity(16'hFFFF);
		random_phase();
		drain();

		$display("sent %0d input items in %0d strings over five capacity settings",
			items_sent, strings_sent);
		$display("checked %0d decoded bytes and %0d/%0d/%0d ok/malformed/over-capacity ends",
			bytes_checked, ok_count, malformed_count, over_count);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
